@@ sv/bdlp_pkg.sv @@
// ----------------------------------------------------------------------------
// bdlp_pkg
// Types, codes and reset constants shared by the button debouncer modules.
// ----------------------------------------------------------------------------
package bdlp_pkg;

  localparam int NumButtons = 8;
  localparam int IdxW       = 3;
  localparam int SlotsMax   = 2 ** IdxW;
  localparam int HistW      = 16;
  localparam int TimeW      = 64;
  localparam int LongW      = 32;
  localparam int PolW       = 8;
  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 32;

  localparam logic [HistW-1:0] HistOnes  = ~(HistW'(0));
  localparam logic [HistW-1:0] HistZeros = HistW'(0);

  localparam logic [HistW-1:0] ActivityMaskReset = 16'd61503;
  localparam logic [HistW-1:0] RisePatternReset  = 16'd63;
  localparam logic [HistW-1:0] FallPatternReset  = 16'd61440;
  localparam logic [LongW-1:0] LongPressReset    = 32'd1000000;
  localparam logic [PolW-1:0]  ActiveLowReset    = 8'd255;

  typedef enum logic [1:0] {
    ST_UP   = 2'd0,
    ST_DOWN = 2'd1,
    ST_LONG = 2'd2
  } button_state_e;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_INIT   = 1'b1
  } opcode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ACTIVITY_MASK = 3'd0,
    CFG_RISE_PATTERN  = 3'd1,
    CFG_FALL_PATTERN  = 3'd2,
    CFG_LONG_PRESS_US = 3'd3,
    CFG_ACTIVE_LOW    = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic            opcode;
    logic [IdxW-1:0] button_index;
    logic            pin_level;
    logic [TimeW-1:0] now_us;
  } in_item_t;

  typedef struct packed {
    logic [IdxW-1:0] event_button;
    logic [1:0]      from_state;
    logic [1:0]      to_state;
  } out_item_t;

  typedef struct packed {
    logic [HistW-1:0] activity_mask;
    logic [HistW-1:0] rise_pattern;
    logic [HistW-1:0] fall_pattern;
    logic [LongW-1:0] long_press_us;
    logic [PolW-1:0]  active_low_mask;
  } cfg_t;

  typedef struct packed {
    logic [HistW-1:0] history;
    button_state_e    state;
    logic [TimeW-1:0] press_time;
  } slot_t;

endpackage

@@ sv/bdlp_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// bdlp_cfg_regs
// Configuration register bank, written through an indexed valid/ready port.
// ----------------------------------------------------------------------------
module bdlp_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bdlp_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [bdlp_pkg::CfgDataW-1:0]  cfg_data_i,
  output bdlp_pkg::cfg_t                 cfg_o
);
  import bdlp_pkg::*;

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.activity_mask   <= ActivityMaskReset;
      cfg_q.rise_pattern    <= RisePatternReset;
      cfg_q.fall_pattern    <= FallPatternReset;
      cfg_q.long_press_us   <= LongPressReset;
      cfg_q.active_low_mask <= ActiveLowReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_ACTIVITY_MASK: cfg_q.activity_mask   <= cfg_data_i[HistW-1:0];
        CFG_RISE_PATTERN:  cfg_q.rise_pattern    <= cfg_data_i[HistW-1:0];
        CFG_FALL_PATTERN:  cfg_q.fall_pattern    <= cfg_data_i[HistW-1:0];
        CFG_LONG_PRESS_US: cfg_q.long_press_us   <= cfg_data_i[LongW-1:0];
        CFG_ACTIVE_LOW:    cfg_q.active_low_mask <= cfg_data_i[PolW-1:0];
        default: ;
      endcase
    end
  end

endmodule

@@ sv/bdlp_slot_file.sv @@
// ----------------------------------------------------------------------------
// bdlp_slot_file
// Per-button history, debounced state and press timestamp, one read port
// and one write port.
// ----------------------------------------------------------------------------
module bdlp_slot_file #(
  parameter int NumSlots = bdlp_pkg::NumButtons
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [bdlp_pkg::IdxW-1:0]   rd_idx_i,
  output logic                        rd_in_range_o,
  output bdlp_pkg::slot_t             rd_slot_o,
  input  logic                        wr_en_i,
  input  logic [bdlp_pkg::IdxW-1:0]   wr_idx_i,
  input  bdlp_pkg::slot_t             wr_slot_i
);
  import bdlp_pkg::*;

  slot_t slot_q [NumSlots];

  for (genvar i = 0; i < NumSlots; i++) begin : g_slot
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        slot_q[i].history    <= ActiveLowReset[i] ? HistOnes : HistZeros;
        slot_q[i].state      <= ST_UP;
        slot_q[i].press_time <= '0;
      end else if (wr_en_i && (wr_idx_i == IdxW'(i))) begin
        slot_q[i] <= wr_slot_i;
      end
    end
  end

  assign rd_in_range_o = ({1'b0, rd_idx_i} < (IdxW + 1)'(NumSlots));

  always_comb begin
    rd_slot_o = '0;
    for (int i = 0; i < NumSlots; i++) begin
      if (rd_idx_i == IdxW'(i)) begin
        rd_slot_o = slot_q[i];
      end
    end
  end

endmodule

@@ sv/bdlp_update.sv @@
// ----------------------------------------------------------------------------
// bdlp_update
// Next-state logic for one item: history shift, pattern match, long-press
// timeout, init seeding and event generation.
// ----------------------------------------------------------------------------
module bdlp_update (
  input  bdlp_pkg::cfg_t      cfg_i,
  input  bdlp_pkg::in_item_t  item_i,
  input  logic                in_range_i,
  input  bdlp_pkg::slot_t     cur_i,
  output bdlp_pkg::slot_t     nxt_o,
  output logic                emit_o,
  output bdlp_pkg::out_item_t result_o
);
  import bdlp_pkg::*;

  logic             low;
  logic [HistW-1:0] shifted;
  logic [HistW-1:0] masked;
  logic             rise_m;
  logic             fall_m;
  logic             down_m;
  logic             up_m;
  logic [TimeW-1:0] held;
  logic             timed_out;
  logic [HistW-1:0] seed;

  assign low       = cfg_i.active_low_mask[item_i.button_index];
  assign seed      = low ? HistOnes : HistZeros;
  assign shifted   = {cur_i.history[HistW-2:0], item_i.pin_level};
  assign masked    = shifted & cfg_i.activity_mask;
  assign rise_m    = (masked == cfg_i.rise_pattern);
  assign fall_m    = (masked == cfg_i.fall_pattern);
  assign down_m    = low ? fall_m : rise_m;
  assign up_m      = low ? rise_m : fall_m;
  assign held      = item_i.now_us - cur_i.press_time;
  assign timed_out = (held > {{(TimeW-LongW){1'b0}}, cfg_i.long_press_us});

  always_comb begin
    nxt_o         = cur_i;
    nxt_o.history = shifted;
    if (item_i.opcode == OP_INIT) begin
      nxt_o.history    = seed;
      nxt_o.press_time = '0;
      nxt_o.state      = (item_i.pin_level ^ low) ? ST_DOWN : ST_UP;
    end else begin
      case (cur_i.state)
        ST_UP: begin
          if (down_m) begin
            nxt_o.history    = ~seed;
            nxt_o.press_time = item_i.now_us;
            nxt_o.state      = ST_DOWN;
          end
        end
        ST_DOWN: begin
          if (up_m) begin
            nxt_o.history = seed;
            nxt_o.state   = ST_UP;
          end else if (timed_out) begin
            nxt_o.state = ST_LONG;
          end
        end
        default: begin
          if (up_m) begin
            nxt_o.history = seed;
            nxt_o.state   = ST_UP;
          end
        end
      endcase
    end
  end

  assign emit_o = in_range_i && (item_i.opcode == OP_SAMPLE) && (nxt_o.state != cur_i.state);

  assign result_o.event_button = item_i.button_index;
  assign result_o.from_state   = cur_i.state;
  assign result_o.to_state     = nxt_o.state;

endmodule

@@ sv/button_debounce_long_press.sv @@
// ----------------------------------------------------------------------------
// button_debounce_long_press
// Shift-register button debouncer with long-press detection, top level.
// ----------------------------------------------------------------------------
// Usage: each input transaction on in_item_i (valid/stall) names a button,
// its raw pin level and the current microsecond time. A sample item shifts
// the level into that button's history; a debounced press, release or
// long-press timeout emits one event transaction on out_item_o (previous and
// new state). Init items seed a button from its level and emit nothing; items
// for buttons at or beyond ButtonCount are dropped.
// Pipeline: an accepted item enters the update stage register, its event the
// output register. Throughput: one item per cycle unless out_stall_i holds;
// the per-button state is read and written in the single update stage, so
// items for the same button may follow each other without gaps.
// Configuration: cfg_valid_i/cfg_ready_o with a register index; ready is
// always high. Write only while the block is idle.
// Reset: all buttons up, press time zero, history all ones for active-low
// buttons, registers take their defaults.
// Stall: while out_stall_i holds a pending event, the update stage holds and
// in_stall_o rises once the stage is occupied.
// ----------------------------------------------------------------------------
module button_debounce_long_press #(
  parameter int ButtonCount = bdlp_pkg::NumButtons
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  bdlp_pkg::in_item_t             in_item_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output bdlp_pkg::out_item_t            out_item_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bdlp_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [bdlp_pkg::CfgDataW-1:0]  cfg_data_i
);
  import bdlp_pkg::*;

  localparam int NumSlots = (ButtonCount < SlotsMax) ? ButtonCount : SlotsMax;

  cfg_t      cfg;
  logic      s1_valid_q;
  in_item_t  s1_item_q;
  logic      out_valid_q;
  out_item_t out_item_q;
  logic      advance;
  logic      fire;
  logic      in_range;
  slot_t     cur_slot;
  slot_t     nxt_slot;
  logic      emit;
  out_item_t result;

  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !advance;
  assign fire       = s1_valid_q && advance;

  bdlp_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  bdlp_slot_file #(
    .NumSlots (NumSlots)
  ) u_slots (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rd_idx_i      (s1_item_q.button_index),
    .rd_in_range_o (in_range),
    .rd_slot_o     (cur_slot),
    .wr_en_i       (fire && in_range),
    .wr_idx_i      (s1_item_q.button_index),
    .wr_slot_i     (nxt_slot)
  );

  bdlp_update u_update (
    .cfg_i      (cfg),
    .item_i     (s1_item_q),
    .in_range_i (in_range),
    .cur_i      (cur_slot),
    .nxt_o      (nxt_slot),
    .emit_o     (emit),
    .result_o   (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= fire && emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_item_q <= in_item_i;
    end
    if (fire) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule
